@@ hw/rtl/evad_pkg.sv @@
// ----------------------------------------------------------------------------
// evad_pkg - shared types and constants for the energy VAD
// Register map, register reset values, fixed field widths and the control
// structs passed between the datapath modules.
// ----------------------------------------------------------------------------
package evad_pkg;

  localparam int ALPHA_W     = 16;  // hpf_alpha, Q0.16
  localparam int THR_W       = 24;  // energy_threshold, 1/256 LSB units
  localparam int ACC_W       = 34;  // energy accumulator / energy_total
  localparam int SEEN_W      = 17;  // samples_seen field
  localparam int THR_SHIFT   = 8;   // threshold fraction bits
  localparam int ROUND_SHIFT = 16;  // Q0.16 product scaling
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [ACC_W-1:0]   ACC_MAX        = '1;
  localparam logic               RST_HPF_ENABLE = 1'b1;
  localparam logic [ALPHA_W-1:0] RST_HPF_ALPHA  = 16'd63060;
  localparam logic [THR_W-1:0]   RST_THRESHOLD  = 24'd839;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HPF_ENABLE       = 2'd0,
    REG_HPF_ALPHA        = 2'd1,
    REG_ENERGY_THRESHOLD = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic               hpf_enable;
    logic [ALPHA_W-1:0] hpf_alpha;
    logic [THR_W-1:0]   energy_threshold;
  } cfg_t;

  // one sample moving down the pipe
  typedef struct packed {
    logic valid;
    logic last;
  } item_ctl_t;

  // decision stage occupancy, seen by the accumulator stage
  typedef struct packed {
    logic take;  // can load a finished buffer this cycle
    logic full;  // product and output registers both occupied
  } dec_stat_t;

endpackage

@@ hw/rtl/evad_if.sv @@
// ----------------------------------------------------------------------------
// evad_if - channel interfaces of the energy VAD
// Sample input stream, result stream and register write channel, each a
// valid/ready channel with source and sink modports.
// ----------------------------------------------------------------------------
interface evad_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

interface evad_out_if
  import evad_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              speech_detected;
  logic [ACC_W-1:0]  energy_total;
  logic [SEEN_W-1:0] samples_seen;

  modport source (output valid, speech_detected, energy_total, samples_seen, input ready);
  modport sink   (input valid, speech_detected, energy_total, samples_seen, output ready);
endinterface

interface evad_cfg_if
  import evad_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/evad_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// evad_cfg_regs - configuration registers
// Filter enable, filter coefficient and energy threshold; write-only port,
// always ready, unknown indexes are dropped.
// ----------------------------------------------------------------------------
module evad_cfg_regs
  import evad_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  evad_cfg_if.sink   cfg_if,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_if.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_HPF_ENABLE:       cfg_nxt.hpf_enable       = cfg_if.data[0];
        REG_HPF_ALPHA:        cfg_nxt.hpf_alpha        = cfg_if.data[ALPHA_W-1:0];
        REG_ENERGY_THRESHOLD: cfg_nxt.energy_threshold = cfg_if.data[THR_W-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hpf_enable       <= RST_HPF_ENABLE;
      cfg_r.hpf_alpha        <= RST_HPF_ALPHA;
      cfg_r.energy_threshold <= RST_THRESHOLD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hw/rtl/evad_hpf.sv @@
// ----------------------------------------------------------------------------
// evad_hpf - input register and one-pole high-pass filter
// y = sat(round(alpha * (y_prev + x - x_prev) / 2^16)); first sample of a
// buffer, or filter off, passes x through. Emits |y| per sample.
// ----------------------------------------------------------------------------
module evad_hpf
  import evad_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_last,
  input  cfg_t                          cfg,
  output item_ctl_t                     item,
  output logic [SAMPLE_BITS+1:0]        mag
);

  localparam int Y_W = SAMPLE_BITS + 2;          // filter output width
  localparam int S_W = Y_W + 1;                  // y_prev + x - x_prev
  localparam int P_W = S_W + ALPHA_W + 1;        // signed product
  localparam int R_W = P_W + 1;                  // product plus rounding half
  localparam int Q_W = R_W - ROUND_SHIFT;        // scaled, before saturation

  item_ctl_t                     in_ctl_r;
  logic signed [SAMPLE_BITS-1:0] x_r;
  item_ctl_t                     out_ctl_r;
  logic [Y_W-1:0]                mag_r;

  logic signed [SAMPLE_BITS-1:0] prev_raw_r;
  logic signed [Y_W-1:0]         y_r;
  logic                          start_r;

  logic signed [S_W-1:0] diff;
  logic signed [P_W-1:0] prod;
  logic signed [R_W-1:0] rnd;
  logic signed [Q_W-1:0] q;
  logic                  q_fits;
  logic signed [Y_W-1:0] y_filt;
  logic signed [Y_W-1:0] y_nxt;
  logic [Y_W-1:0]        mag_nxt;
  logic                  in_fire;

  assign in_fire = in_valid && adv;
  assign item    = out_ctl_r;
  assign mag     = mag_r;

  always_comb begin
    diff = {y_r[Y_W-1], y_r}
         + {{(S_W-SAMPLE_BITS){x_r[SAMPLE_BITS-1]}}, x_r}
         - {{(S_W-SAMPLE_BITS){prev_raw_r[SAMPLE_BITS-1]}}, prev_raw_r};
    prod = diff * $signed({1'b0, cfg.hpf_alpha});
    // round half up: floor((p + 2^15) / 2^16)
    rnd  = {prod[P_W-1], prod} + (R_W'(1) << (ROUND_SHIFT-1));
    q    = rnd[R_W-1:ROUND_SHIFT];
    q_fits = (&q[Q_W-1:Y_W-1]) || !(|q[Q_W-1:Y_W-1]);
    if (q_fits) begin
      y_filt = q[Y_W-1:0];
    end else if (q[Q_W-1]) begin
      y_filt = {1'b1, {(Y_W-1){1'b0}}};
    end else begin
      y_filt = {1'b0, {(Y_W-1){1'b1}}};
    end
    if (cfg.hpf_enable && !start_r) begin
      y_nxt = y_filt;
    end else begin
      y_nxt = {{2{x_r[SAMPLE_BITS-1]}}, x_r};
    end
    mag_nxt = y_nxt[Y_W-1] ? (~y_nxt + 1'b1) : y_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ctl_r   <= '0;
      out_ctl_r  <= '0;
      prev_raw_r <= '0;
      y_r        <= '0;
      start_r    <= 1'b1;
    end else if (adv) begin
      in_ctl_r.valid <= in_fire;
      in_ctl_r.last  <= in_last;
      out_ctl_r      <= in_ctl_r;
      if (in_ctl_r.valid) begin
        y_r        <= y_nxt;
        prev_raw_r <= x_r;
        start_r    <= in_ctl_r.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r   <= in_sample;
      mag_r <= mag_nxt;
    end
  end

endmodule

@@ hw/rtl/evad_energy.sv @@
// ----------------------------------------------------------------------------
// evad_energy - energy accumulator and sample counter
// Saturating sum of |y| and sample count per buffer; on the last word the
// totals move to a holding register for the decision stage.
// ----------------------------------------------------------------------------
module evad_energy
  import evad_pkg::*;
#(
  parameter int MAX_SAMPLES = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  item_ctl_t                          item,
  input  logic [SAMPLE_BITS+1:0]             mag,
  input  dec_stat_t                          dstat,
  output logic                               adv,
  output logic                               fin_valid,
  output logic [ACC_W-1:0]                   fin_acc,
  output logic [$clog2(MAX_SAMPLES+1)-1:0]   fin_cnt
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

  logic [ACC_W-1:0] acc_r;
  logic [CNT_W-1:0] cnt_r;
  logic             fin_valid_r;
  logic [ACC_W-1:0] fin_acc_r;
  logic [CNT_W-1:0] fin_cnt_r;

  logic [ACC_W:0]   acc_sum;
  logic [ACC_W-1:0] acc_nxt;
  logic [CNT_W-1:0] cnt_nxt;
  logic             step;
  logic             done;

  // hold the sample pipe only when every result slot is occupied
  assign adv  = !(fin_valid_r && dstat.full);
  assign step = adv && item.valid;
  assign done = step && item.last;

  assign fin_valid = fin_valid_r;
  assign fin_acc   = fin_acc_r;
  assign fin_cnt   = fin_cnt_r;

  always_comb begin
    acc_sum = {1'b0, acc_r} + (ACC_W+1)'(mag);
    acc_nxt = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
    cnt_nxt = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      fin_valid_r <= 1'b0;
    end else begin
      fin_valid_r <= (fin_valid_r && !dstat.take) || done;
      if (step) begin
        if (item.last) begin
          acc_r <= '0;
          cnt_r <= '0;
        end else begin
          acc_r <= acc_nxt;
          cnt_r <= cnt_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      fin_acc_r <= acc_nxt;
      fin_cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ hw/rtl/evad_decide.sv @@
// ----------------------------------------------------------------------------
// evad_decide - threshold decision and result register
// threshold * count is registered, then compared against 256 * sum; the
// verdict and totals sit in the output register until taken.
// ----------------------------------------------------------------------------
module evad_decide
  import evad_pkg::*;
#(
  parameter int MAX_SAMPLES = 65536
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cfg_t                             cfg,
  input  logic                             fin_valid,
  input  logic [ACC_W-1:0]                 fin_acc,
  input  logic [$clog2(MAX_SAMPLES+1)-1:0] fin_cnt,
  output dec_stat_t                        dstat,
  evad_out_if.source                       out_if
);

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int PROD_W = THR_W + CNT_W;
  localparam int LHS_W  = ACC_W + THR_SHIFT;
  localparam int CMP_W  = (PROD_W > LHS_W) ? PROD_W : LHS_W;
  localparam int EXT_W  = CNT_W + SEEN_W;

  logic              prod_valid_r;
  logic [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]  prod_acc_r;
  logic [CNT_W-1:0]  prod_cnt_r;

  logic              out_valid_r;
  logic              speech_r;
  logic [ACC_W-1:0]  energy_r;
  logic [SEEN_W-1:0] seen_r;

  logic              out_ok;
  logic              take;
  logic              prod_move;
  logic              fin_move;
  logic [PROD_W-1:0] prod_nxt;
  logic [CMP_W-1:0]  lhs;
  logic [CMP_W-1:0]  rhs;
  logic [EXT_W-1:0]  cnt_ext;

  assign out_ok    = !out_valid_r || out_if.ready;
  assign take      = !prod_valid_r || out_ok;
  assign prod_move = prod_valid_r && out_ok;
  assign fin_move  = fin_valid && take;

  assign dstat.take = take;
  assign dstat.full = prod_valid_r && out_valid_r;

  assign out_if.valid           = out_valid_r;
  assign out_if.speech_detected = speech_r;
  assign out_if.energy_total    = energy_r;
  assign out_if.samples_seen    = seen_r;

  always_comb begin
    prod_nxt = PROD_W'(cfg.energy_threshold) * PROD_W'(fin_cnt);
    lhs      = CMP_W'({prod_acc_r, {THR_SHIFT{1'b0}}});
    rhs      = CMP_W'(prod_r);
    cnt_ext  = EXT_W'(prod_cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      prod_valid_r <= fin_move || (prod_valid_r && !out_ok);
      out_valid_r  <= prod_move || (out_valid_r && !out_if.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (fin_move) begin
      prod_r     <= prod_nxt;
      prod_acc_r <= fin_acc;
      prod_cnt_r <= fin_cnt;
    end
    if (prod_move) begin
      speech_r <= (lhs >= rhs);
      energy_r <= prod_acc_r;
      seen_r   <= cnt_ext[SEEN_W-1:0];
    end
  end

endmodule

@@ hw/rtl/energy_vad_with_highpass.sv @@
// ----------------------------------------------------------------------------
// energy_vad_with_highpass - energy threshold voice activity detector
// Optional one-pole high-pass filter, per-buffer energy sum and decision.
// ----------------------------------------------------------------------------
// Usage:
//   in_if   : one audio sample per word, signed SAMPLE_BITS, with a last flag
//             that closes the buffer.
//   out_if  : one word per buffer: speech flag, saturated sum of |y| and the
//             sample count (saturated at MAX_SAMPLES, low 17 bits shown).
//   cfg_if  : register writes (0 filter enable, 1 alpha Q0.16, 2 threshold in
//             1/256 LSB); always ready, write only while the block is idle.
//   Throughput: one sample word per cycle while in_if.ready is high, set
//   by the filter feedback loop (multiply, round, saturate) around y_r.
//   Result path: the last sample of a buffer passes the input reg, filter,
//   accumulator, product and output registers before the word is valid.
//   Reset: registers go to their defaults, filter and sums clear, the next
//   sample starts a new buffer.
//   Stall: up to three finished buffers are held (accumulator, product and
//   output stages); in_if.ready drops only when all three are occupied.
// ----------------------------------------------------------------------------
module energy_vad_with_highpass
  import evad_pkg::*;
#(
  parameter int MAX_SAMPLES = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  evad_in_if.sink    in_if,
  evad_out_if.source out_if,
  evad_cfg_if.sink   cfg_if
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

  cfg_t                   cfg;
  logic                   adv;
  item_ctl_t              item;
  logic [SAMPLE_BITS+1:0] mag;
  dec_stat_t              dstat;
  logic                   fin_valid;
  logic [ACC_W-1:0]       fin_acc;
  logic [CNT_W-1:0]       fin_cnt;

  // sample pipe advances unless every result slot is full
  assign in_if.ready = adv;

  evad_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  evad_hpf #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_hpf (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_if.valid),
    .in_sample (in_if.sample),
    .in_last   (in_if.last),
    .cfg       (cfg),
    .item      (item),
    .mag       (mag)
  );

  evad_energy #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_energy (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .mag       (mag),
    .dstat     (dstat),
    .adv       (adv),
    .fin_valid (fin_valid),
    .fin_acc   (fin_acc),
    .fin_cnt   (fin_cnt)
  );

  // decision: 256 * sum >= threshold * count
  evad_decide #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_decide (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .fin_valid (fin_valid),
    .fin_acc   (fin_acc),
    .fin_cnt   (fin_cnt),
    .dstat     (dstat),
    .out_if    (out_if)
  );

endmodule
